FILE: src/spb_pkg.sv
// ----------------------------------------------------------------------------
// spb_pkg: shared definitions for the hop count and bottleneck block
// Sizes, request codes, sequencer states and small helpers.
// ----------------------------------------------------------------------------
package spb_pkg;

  localparam int unsigned NumDevices = 64;
  localparam int unsigned NodeW      = $clog2(NumDevices);
  localparam int unsigned AddrW      = 2 * NodeW;
  localparam int unsigned MemDepth   = 1 << AddrW;
  localparam int unsigned FieldNodeW = 6;
  localparam int unsigned CapW       = 8;
  localparam int unsigned HopsW      = 6;
  localparam int unsigned HopsMax    = 63;

  typedef logic [NodeW-1:0] node_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CapW-1:0]  cap_t;
  typedef logic [HopsW-1:0] hops_t;

  localparam node_t NodeLast   = NodeW'(NumDevices - 1);
  localparam addr_t AddrLast   = AddrW'(MemDepth - 1);
  localparam cap_t  CapAllOnes = '1;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } spb_kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIRECT_RD,
    ST_DIRECT_CHK,
    ST_LEVEL,
    ST_ROW,
    ST_DRAIN,
    ST_LEVEL_END,
    ST_WALK,
    ST_WALK_PAR,
    ST_WALK_CAP,
    ST_EMIT
  } spb_state_e;

  // Node field lies inside the device range
  function automatic logic node_in_range(logic [FieldNodeW-1:0] n);
    return 32'(n) < NumDevices;
  endfunction

endpackage

FILE: src/spb_channels.sv
// ----------------------------------------------------------------------------
// spb channels: request and response interfaces
// Valid/ready channels carrying link writes, path queries and their results.
// ----------------------------------------------------------------------------
interface spb_req_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [spb_pkg::FieldNodeW-1:0]    source_node;
  logic [spb_pkg::FieldNodeW-1:0]    dest_node;
  logic [spb_pkg::CapW-1:0]          link_capacity;

  modport source (output valid, kind, source_node, dest_node, link_capacity, input ready);
  modport sink   (input valid, kind, source_node, dest_node, link_capacity, output ready);
endinterface

interface spb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          reachable;
  logic [spb_pkg::HopsW-1:0]     hops;
  logic [spb_pkg::CapW-1:0]      min_capacity;

  modport source (output valid, reachable, hops, min_capacity, input ready);
  modport sink   (input valid, reachable, hops, min_capacity, output ready);
endinterface

FILE: src/shortest_path_hop_and_bottleneck.sv
// ----------------------------------------------------------------------------
// shortest_path_hop_and_bottleneck: hop count and bottleneck over a link matrix
// Holds a directed capacity matrix and answers shortest path queries by a
// level-by-level search that reads one matrix entry per cycle while it scans a row.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per handshake: a link write (kind 0) stores a
//   capacity at row source_node, column dest_node; a path query (kind 1)
//   yields one response on rsp_o, a write yields none.
//   After reset the link memory is swept to zero, one entry a cycle, over all
//   MemDepth (4096) entries; req_i.ready stays low during the sweep.
//   A write is stored as it is accepted. A query with a direct link or with
//   source equal to destination passes through DIRECT_RD, DIRECT_CHK and EMIT
//   to its response, one that names a node out of range straight to EMIT.
//   Otherwise the search scans every index at each level (N = 64), reads the
//   full matrix row of each node in the level, and walks the path back link
//   by link through the parent memory; the single read port of the link
//   memory bounds how fast this runs.
//   The block takes one request at a time and is ready only when idle.
//   A finished response waits in the output register; the next request is
//   accepted meanwhile, and a second response waits until rsp_o is taken.
// ----------------------------------------------------------------------------
module shortest_path_hop_and_bottleneck (
  input  logic            clk_i,
  input  logic            rst_ni,
  spb_req_if.sink         req_i,
  spb_rsp_if.source       rsp_o
);

  spb_pkg::spb_state_e state_q, state_d;

  // Link memory, single write and single registered read port
  spb_pkg::cap_t  link_mem [spb_pkg::MemDepth];
  spb_pkg::cap_t  mem_rdata_q;
  logic           mem_we;
  spb_pkg::addr_t mem_waddr;
  spb_pkg::cap_t  mem_wdata;
  spb_pkg::addr_t mem_raddr;

  // Parent memory, written by the search and read by the walk back
  spb_pkg::node_t par_mem [spb_pkg::NumDevices];
  spb_pkg::node_t par_rdata_q;

  // Clearing sweep
  spb_pkg::addr_t clr_q;

  // Query and search state
  spb_pkg::node_t src_q, dst_q;
  spb_pkg::node_t u_q, v_q;
  logic [spb_pkg::NumDevices-1:0] found_q, front_q, next_q;

  // Row read pipeline: entry (u_q, p_v_q) is in mem_rdata_q when p_vld_q
  logic           p_vld_q;
  spb_pkg::node_t p_v_q;
  logic           proc_hit;

  // Walk back
  spb_pkg::node_t cur_q, prev_q;
  spb_pkg::node_t links_q;
  spb_pkg::cap_t  mn_q;
  spb_pkg::node_t links_m1;
  spb_pkg::hops_t hops_calc;

  // Pending result and output register
  logic           res_reach_q;
  spb_pkg::hops_t res_hops_q;
  spb_pkg::cap_t  res_cap_q;
  logic           rsp_vld_q;
  logic           rsp_reach_q;
  spb_pkg::hops_t rsp_hops_q;
  spb_pkg::cap_t  rsp_cap_q;

  // Sequencer strobes
  logic           req_ready;
  logic           q_capture;
  logic           clr_inc;
  logic           init_search;
  logic           u_inc;
  logic           v_clr;
  logic           v_inc;
  logic           issue;
  logic           level_end;
  logic           walk_start;
  logic           walk_par;
  logic           walk_step;
  logic           res_load;
  logic           res_reach;
  spb_pkg::hops_t res_hops;
  spb_pkg::cap_t  res_cap;
  logic           out_load;

  // A newly found node: read entry non-zero and node not yet visited
  assign proc_hit = p_vld_q && (mem_rdata_q != '0) && !found_q[p_v_q];

  // Path links minus one, saturated to the hop field
  always_comb begin
    links_m1 = (links_q == '0) ? '0 : links_q - spb_pkg::NodeW'(1);
    if (32'(links_m1) > spb_pkg::HopsMax) begin
      hops_calc = spb_pkg::HopsW'(spb_pkg::HopsMax);
    end else begin
      hops_calc = spb_pkg::HopsW'(links_m1);
    end
  end

  // --------------------------------------------------------------------------
  // State register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spb_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state and strobes
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    req_ready   = 1'b0;
    q_capture   = 1'b0;
    clr_inc     = 1'b0;
    init_search = 1'b0;
    u_inc       = 1'b0;
    v_clr       = 1'b0;
    v_inc       = 1'b0;
    issue       = 1'b0;
    level_end   = 1'b0;
    walk_start  = 1'b0;
    walk_par    = 1'b0;
    walk_step   = 1'b0;
    res_load    = 1'b0;
    res_reach   = 1'b0;
    res_hops    = '0;
    res_cap     = '0;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = '0;
    mem_raddr   = {u_q, v_q};

    unique case (state_q)
      spb_pkg::ST_CLEAR: begin
        // Sweep the link memory to zero
        mem_we  = 1'b1;
        clr_inc = 1'b1;
        if (clr_q == spb_pkg::AddrLast) begin
          state_d = spb_pkg::ST_IDLE;
        end
      end

      spb_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.kind == spb_pkg::KIND_WRITE) begin
            // Drop writes outside the matrix
            if (spb_pkg::node_in_range(req_i.source_node) &&
                spb_pkg::node_in_range(req_i.dest_node)) begin
              mem_we    = 1'b1;
              mem_waddr = {spb_pkg::NodeW'(req_i.source_node),
                           spb_pkg::NodeW'(req_i.dest_node)};
              mem_wdata = req_i.link_capacity;
            end
          end else begin
            q_capture = 1'b1;
            if (spb_pkg::node_in_range(req_i.source_node) &&
                spb_pkg::node_in_range(req_i.dest_node)) begin
              state_d = spb_pkg::ST_DIRECT_RD;
            end else begin
              res_load = 1'b1;
              state_d  = spb_pkg::ST_EMIT;
            end
          end
        end
      end

      spb_pkg::ST_DIRECT_RD: begin
        mem_raddr = {src_q, dst_q};
        state_d   = spb_pkg::ST_DIRECT_CHK;
      end

      spb_pkg::ST_DIRECT_CHK: begin
        if (mem_rdata_q != '0) begin
          res_load  = 1'b1;
          res_reach = 1'b1;
          res_cap   = mem_rdata_q;
          state_d   = spb_pkg::ST_EMIT;
        end else if (src_q == dst_q) begin
          res_load  = 1'b1;
          res_reach = 1'b1;
          res_cap   = spb_pkg::CapAllOnes;
          state_d   = spb_pkg::ST_EMIT;
        end else begin
          init_search = 1'b1;
          state_d     = spb_pkg::ST_LEVEL;
        end
      end

      spb_pkg::ST_LEVEL: begin
        // Stop before the next row once the destination has a parent
        priority if (found_q[dst_q]) begin
          walk_start = 1'b1;
          state_d    = spb_pkg::ST_WALK;
        end else if (front_q[u_q]) begin
          v_clr   = 1'b1;
          state_d = spb_pkg::ST_ROW;
        end else if (u_q == spb_pkg::NodeLast) begin
          state_d = spb_pkg::ST_LEVEL_END;
        end else begin
          u_inc = 1'b1;
        end
      end

      spb_pkg::ST_ROW: begin
        mem_raddr = {u_q, v_q};
        issue     = 1'b1;
        if (v_q == spb_pkg::NodeLast) begin
          state_d = spb_pkg::ST_DRAIN;
        end else begin
          v_inc = 1'b1;
        end
      end

      spb_pkg::ST_DRAIN: begin
        if (u_q == spb_pkg::NodeLast) begin
          state_d = spb_pkg::ST_LEVEL_END;
        end else begin
          u_inc   = 1'b1;
          state_d = spb_pkg::ST_LEVEL;
        end
      end

      spb_pkg::ST_LEVEL_END: begin
        if (next_q == '0) begin
          res_load = 1'b1;
          state_d  = spb_pkg::ST_EMIT;
        end else begin
          level_end = 1'b1;
          state_d   = spb_pkg::ST_LEVEL;
        end
      end

      spb_pkg::ST_WALK: begin
        if (cur_q == src_q) begin
          res_load  = 1'b1;
          res_reach = 1'b1;
          res_hops  = hops_calc;
          res_cap   = mn_q;
          state_d   = spb_pkg::ST_EMIT;
        end else begin
          state_d = spb_pkg::ST_WALK_PAR;
        end
      end

      spb_pkg::ST_WALK_PAR: begin
        // Parent of cur_q is ready; fetch the link parent -> cur_q
        mem_raddr = {par_rdata_q, cur_q};
        walk_par  = 1'b1;
        state_d   = spb_pkg::ST_WALK_CAP;
      end

      spb_pkg::ST_WALK_CAP: begin
        walk_step = 1'b1;
        state_d   = spb_pkg::ST_WALK;
      end

      spb_pkg::ST_EMIT: begin
        // Hold the result until the output register is free
        if (!rsp_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = spb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = spb_pkg::ST_CLEAR;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= link_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (proc_hit) begin
      par_mem[p_v_q] <= u_q;
    end
    par_rdata_q <= par_mem[cur_q];
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      u_q       <= '0;
      v_q       <= '0;
      p_vld_q   <= 1'b0;
      found_q   <= '0;
      front_q   <= '0;
      next_q    <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (clr_inc) begin
        clr_q <= clr_q + spb_pkg::AddrW'(1);
      end

      if (init_search || level_end) begin
        u_q <= '0;
      end else if (u_inc) begin
        u_q <= u_q + spb_pkg::NodeW'(1);
      end

      if (v_clr) begin
        v_q <= '0;
      end else if (v_inc) begin
        v_q <= v_q + spb_pkg::NodeW'(1);
      end

      p_vld_q <= issue;

      // Visited set, current level and next level
      if (init_search) begin
        found_q <= spb_pkg::NumDevices'(1) << src_q;
        front_q <= spb_pkg::NumDevices'(1) << src_q;
        next_q  <= '0;
      end else if (level_end) begin
        front_q <= next_q;
        next_q  <= '0;
      end else if (proc_hit) begin
        found_q[p_v_q] <= 1'b1;
        next_q[p_v_q]  <= 1'b1;
      end

      if (out_load) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (q_capture) begin
      src_q <= spb_pkg::NodeW'(req_i.source_node);
      dst_q <= spb_pkg::NodeW'(req_i.dest_node);
    end

    p_v_q <= v_q;

    if (walk_start) begin
      cur_q   <= dst_q;
      links_q <= '0;
      mn_q    <= spb_pkg::CapAllOnes;
    end else if (walk_step) begin
      if (mem_rdata_q < mn_q) begin
        mn_q <= mem_rdata_q;
      end
      links_q <= links_q + spb_pkg::NodeW'(1);
      cur_q   <= prev_q;
    end

    if (walk_par) begin
      prev_q <= par_rdata_q;
    end

    if (res_load) begin
      res_reach_q <= res_reach;
      res_hops_q  <= res_hops;
      res_cap_q   <= res_cap;
    end

    if (out_load) begin
      rsp_reach_q <= res_reach_q;
      rsp_hops_q  <= res_hops_q;
      rsp_cap_q   <= res_cap_q;
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign req_i.ready        = req_ready;
  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.reachable    = rsp_reach_q;
  assign rsp_o.hops         = rsp_hops_q;
  assign rsp_o.min_capacity = rsp_cap_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // The source stays visited throughout the search
  a_src_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spb_pkg::ST_LEVEL) |-> found_q[src_q])
    else $error("search source not marked visited");

  // A level is only scanned while it holds at least one node
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spb_pkg::ST_LEVEL) |-> (front_q != '0))
    else $error("empty level scanned");

  // Row data is only processed for reads issued by the row scan
  a_proc_from_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> ($past(state_q) == spb_pkg::ST_ROW))
    else $error("row data processed without a row read");

  // The walk back only passes through visited nodes
  a_walk_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spb_pkg::ST_WALK) |-> found_q[cur_q])
    else $error("walk reached an unvisited node");
`endif

endmodule
